// File: sv/hpse_pkg.sv
package hpse_pkg;

    localparam logic [7:0] NAL_TYPE_MASK = 8'h7E;
    localparam logic [5:0] TYPE_VPS      = 6'd32;
    localparam logic [5:0] TYPE_SPS      = 6'd33;
    localparam logic [5:0] TYPE_PPS      = 6'd34;
    localparam logic [7:0] START_LAST    = 8'h01;
    localparam logic [7:0] EP_BYTE       = 8'h03;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] nal_kind;
        logic       has_byte;
        logic       unit_end;
    } t_out_item;

endpackage

// File: sv/hpse_if.sv
interface hpse_in_if;
    import hpse_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface hpse_out_if;
    import hpse_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/hevc_parameter_set_extractor_unit.sv
// Pulls VPS, SPS and PPS units out of an H.265 Annex B byte stream taken one
// byte per item on i_in. Each kept unit comes out byte by byte, header
// included and emulation-prevention bytes removed, tagged with its kind, and
// is closed by a byteless end marker. One input byte produces between zero
// and five result items (held zeros, the byte itself, an end marker); they
// are parked in a small result register and drained one per cycle while
// o_out is ready. A new byte is taken in the same cycle the last pending
// result leaves, so the block takes one byte per clock while o_out is ready
// and each byte gives at most one result, else it waits for pending results.
module hevc_parameter_set_extractor_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpse_in_if.sink    i_in,
    hpse_out_if.source o_out
);
    import hpse_pkg::*;

    // parser state
    logic [1:0] r_held, n_held;
    logic       r_in_unit, n_in_unit;
    logic       r_expect, n_expect;
    logic       r_kept, n_kept;
    logic [1:0] r_kind, n_kind;
    logic [1:0] r_emitted, n_emitted;
    logic [1:0] r_prior, n_prior;

    // pending results of the last accepted item: zeros, then data, then end
    logic [1:0] r_b_zeros, n_b_zeros;
    logic       r_b_dv, n_b_dv;
    logic [7:0] r_b_data, n_b_data;
    logic       r_b_end, n_b_end;
    logic [1:0] r_b_kind, n_b_kind;

    logic [2:0] remaining;
    logic       in_fire;
    logic       out_fire;

    logic [7:0] b;
    logic [5:0] nal_type;
    logic       hdr_kept;
    logic       body;
    logic [1:0] em_z;
    logic       drop;

    function automatic logic [1:0] sat2(input logic [2:0] v);
        sat2 = (v >= 3'd2) ? 2'd2 : v[1:0];
    endfunction

    assign remaining = {1'b0, r_b_zeros} + {2'b00, r_b_dv} + {2'b00, r_b_end};
    assign i_in.ready = (remaining == 3'd0) || ((remaining == 3'd1) && o_out.ready);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign o_out.valid         = (remaining != 3'd0);
    assign o_out.item.has_byte = (r_b_zeros != 2'd0) || r_b_dv;
    assign o_out.item.unit_end = !o_out.item.has_byte;
    assign o_out.item.out_byte = ((r_b_zeros == 2'd0) && r_b_dv) ? r_b_data : 8'h00;
    assign o_out.item.nal_kind = r_b_kind;

    assign b        = i_in.item.data_byte;
    assign nal_type = 6'((b & NAL_TYPE_MASK) >> 1);
    assign hdr_kept = (nal_type == TYPE_VPS) || (nal_type == TYPE_SPS) ||
                      (nal_type == TYPE_PPS);
    assign body     = r_in_unit && r_kept;

    always_comb begin
        n_held    = r_held;
        n_in_unit = r_in_unit;
        n_expect  = r_expect;
        n_kept    = r_kept;
        n_kind    = r_kind;
        n_emitted = r_emitted;
        n_prior   = r_prior;
        n_b_zeros = 2'd0;
        n_b_dv    = 1'b0;
        n_b_data  = b;
        n_b_end   = 1'b0;
        n_b_kind  = r_kind;
        em_z      = 2'd0;
        drop      = 1'b0;

        if (r_expect) begin
            n_expect  = 1'b0;
            n_in_unit = 1'b1;
            n_kept    = hdr_kept;
            n_kind    = hdr_kept ? 2'(nal_type - TYPE_VPS) : 2'd0;
            n_b_kind  = n_kind;
            n_b_dv    = hdr_kept;
            n_emitted = hdr_kept ? 2'd1 : 2'd0;
            n_held    = {1'b0, (b == 8'h00)};
            n_prior   = n_held;
        end else if ((b == START_LAST) && (r_held >= 2'd2)) begin
            n_b_end   = body;
            n_in_unit = 1'b0;
            n_kept    = 1'b0;
            n_kind    = 2'd0;
            n_emitted = 2'd0;
            n_expect  = 1'b1;
            n_held    = 2'd0;
            n_prior   = 2'd0;
        end else if (b == 8'h00) begin
            // a fourth zero in a row pushes out the oldest held one
            if (r_held == 2'd3) begin
                if (body) begin
                    n_b_zeros = 2'd1;
                    n_emitted = sat2({1'b0, r_emitted} + 3'd1);
                end
            end else begin
                n_held = r_held + 2'd1;
            end
            if (r_prior < 2'd2) begin
                n_prior = r_prior + 2'd1;
            end
        end else begin
            if (body) begin
                n_b_zeros = r_held;
                em_z      = sat2({1'b0, r_emitted} + {1'b0, r_held});
                drop      = (em_z == 2'd2) && (b == EP_BYTE) && (r_prior >= 2'd2);
                n_b_dv    = !drop;
                n_emitted = sat2({1'b0, em_z} + {2'b00, !drop});
            end
            n_held  = 2'd0;
            n_prior = 2'd0;
        end

        if (i_in.item.last_byte) begin
            // one trailing zero is dropped, the rest go out before the end marker
            if (n_in_unit && n_kept) begin
                if (n_held > 2'd1) begin
                    n_b_zeros = n_b_zeros + (n_held - 2'd1);
                end
                n_b_end = 1'b1;
            end
            n_held    = 2'd0;
            n_in_unit = 1'b0;
            n_expect  = 1'b0;
            n_kept    = 1'b0;
            n_kind    = 2'd0;
            n_emitted = 2'd0;
            n_prior   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 2'd0;
            r_in_unit <= 1'b0;
            r_expect  <= 1'b0;
            r_kept    <= 1'b0;
            r_kind    <= 2'd0;
            r_emitted <= 2'd0;
            r_prior   <= 2'd0;
            r_b_zeros <= 2'd0;
            r_b_dv    <= 1'b0;
            r_b_end   <= 1'b0;
        end else if (in_fire) begin
            r_held    <= n_held;
            r_in_unit <= n_in_unit;
            r_expect  <= n_expect;
            r_kept    <= n_kept;
            r_kind    <= n_kind;
            r_emitted <= n_emitted;
            r_prior   <= n_prior;
            r_b_zeros <= n_b_zeros;
            r_b_dv    <= n_b_dv;
            r_b_end   <= n_b_end;
        end else if (out_fire) begin
            if (r_b_zeros != 2'd0) begin
                r_b_zeros <= r_b_zeros - 2'd1;
            end else if (r_b_dv) begin
                r_b_dv <= 1'b0;
            end else begin
                r_b_end <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_data <= n_b_data;
            r_b_kind <= n_b_kind;
        end
    end

endmodule

// File: sim/tb_hevc_parameter_set_extractor_unit.sv
`timescale 1ns / 1ps

module tb_hevc_parameter_set_extractor_unit;
    import hpse_pkg::*;

    localparam int RANDOM_BYTES   = 210;
    localparam int QUIET_TAIL     = 40;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 30;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hpse_in_if  in_if ();
    hpse_out_if out_if ();

    hevc_parameter_set_extractor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_item  pending_bytes[$];
    t_out_item expected_results[$];

    int unsigned total_bytes;
    int unsigned bytes_taken;
    int unsigned results_seen;
    int unsigned closes_seen;
    int unsigned streams_built;
    int unsigned errors;
    int unsigned drive_gap;
    int unsigned sink_stall;
    int unsigned quiet_cycles;

    // parser state mirror
    logic [1:0] zeros_held  = '0;
    logic       unit_open   = 1'b0;
    logic       header_next = 1'b0;
    logic       unit_keep   = 1'b0;
    logic [1:0] cur_kind    = '0;
    logic [1:0] bytes_out   = '0;
    logic [1:0] zero_run    = '0;

    task automatic clear_parser();
        zeros_held  = '0;
        unit_open   = 1'b0;
        header_next = 1'b0;
        unit_keep   = 1'b0;
        cur_kind    = '0;
        bytes_out   = '0;
        zero_run    = '0;
    endtask

    task automatic emit(input logic [7:0] b, input logic is_byte);
        t_out_item r;
        r.out_byte = is_byte ? b : 8'h00;
        r.nal_kind = cur_kind;
        r.has_byte = is_byte;
        r.unit_end = !is_byte;
        expected_results = {expected_results, r};
        if (is_byte && bytes_out < 2'd2)
            bytes_out++;
    endtask

    task automatic predict_byte(input t_in_item it);
        logic [5:0] nal_type;
        logic       body;
        nal_type = it.data_byte[6:1];
        body = unit_open && unit_keep;
        if (header_next) begin
            header_next = 1'b0;
            unit_open   = 1'b1;
            bytes_out   = '0;
            unit_keep   = (nal_type == TYPE_VPS) || (nal_type == TYPE_SPS) ||
                          (nal_type == TYPE_PPS);
            cur_kind    = unit_keep ? 2'(nal_type - TYPE_VPS) : 2'd0;
            if (unit_keep)
                emit(it.data_byte, 1'b1);
            zeros_held = (it.data_byte == 8'h00) ? 2'd1 : 2'd0;
            zero_run   = zeros_held;
        end else if (it.data_byte == START_LAST && zeros_held >= 2'd2) begin
            if (body)
                emit(8'h00, 1'b0);
            unit_open   = 1'b0;
            unit_keep   = 1'b0;
            cur_kind    = '0;
            bytes_out   = '0;
            header_next = 1'b1;
            zeros_held  = '0;
            zero_run    = '0;
        end else if (it.data_byte == 8'h00) begin
            // a fourth zero in a row pushes the oldest one out
            if (zeros_held == 2'd3) begin
                if (body)
                    emit(8'h00, 1'b1);
            end else begin
                zeros_held++;
            end
            if (zero_run < 2'd2)
                zero_run++;
        end else begin
            if (body) begin
                while (zeros_held > 0) begin
                    emit(8'h00, 1'b1);
                    zeros_held--;
                end
                if (!(bytes_out >= 2'd2 && it.data_byte == EP_BYTE && zero_run >= 2'd2))
                    emit(it.data_byte, 1'b1);
            end
            zeros_held = '0;
            zero_run   = '0;
        end
        if (it.last_byte) begin
            // one trailing zero is dropped at end of stream
            if (unit_open && unit_keep) begin
                while (zeros_held > 2'd1) begin
                    emit(8'h00, 1'b1);
                    zeros_held--;
                end
                emit(8'h00, 1'b0);
            end
            clear_parser();
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = last;
        pending_bytes = {pending_bytes, it};
    endtask

    function automatic logic [7:0] nal_header(input logic [5:0] t, input logic hi,
                                              input logic lo);
        return {hi, t, lo};
    endfunction

    task automatic add_random_stream();
        logic [5:0] nal_type;
        streams_built++;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(4, 16)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // junk ahead of the first start code
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(1, 4)) begin
                repeat ($urandom_range(0, 2)) add_byte(8'h00, 1'b0);
                add_byte(8'h00, 1'b0);
                add_byte(8'h00, 1'b0);
                add_byte(START_LAST, 1'b0);
                case ($urandom_range(0, 9))
                    0: add_byte(8'h00, 1'b0);
                    1, 2: add_byte(8'($urandom_range(0, 255)), 1'b0);
                    default: begin
                        nal_type = TYPE_VPS + 6'($urandom_range(0, 2));
                        add_byte(nal_header(nal_type, 1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))), 1'b0);
                    end
                endcase
                repeat ($urandom_range(0, 10)) begin
                    case ($urandom_range(0, 9))
                        0, 1: add_byte(8'h00, 1'b0);
                        2: begin
                            add_byte(8'h00, 1'b0);
                            add_byte(8'h00, 1'b0);
                            add_byte(EP_BYTE, 1'b0);
                        end
                        3: add_byte(EP_BYTE, 1'b0);
                        4: repeat ($urandom_range(3, 5)) add_byte(8'h00, 1'b0);
                        default: add_byte(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
            end
            case ($urandom_range(0, 3))
                0: begin
                    add_byte(8'h00, 1'b0);
                    add_byte(8'h00, 1'b0);
                    add_byte(START_LAST, 1'b0);
                end
                1: repeat ($urandom_range(1, 3)) add_byte(8'h00, 1'b0);
                default: add_byte(8'($urandom_range(1, 255)), 1'b0);
            endcase
        end
        pending_bytes[pending_bytes.size() - 1].last_byte = 1'b1;
    endtask

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     results_seen, what, got, want);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_proc
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.item  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_byte(in_if.item);
                bytes_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (drive_gap > 0) begin
                    drive_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() >= QUIET_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    drive_gap = $urandom_range(0, 2);
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    in_if.item  <= pending_bytes.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor_proc
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (out_if.item.unit_end)
                    closes_seen++;
                if (expected_results.size() == 0) begin
                    report("result with nothing pending, out_byte",
                           32'(out_if.item.out_byte), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.item.out_byte !== want.out_byte)
                        report("out_byte", 32'(out_if.item.out_byte), 32'(want.out_byte));
                    if (out_if.item.nal_kind !== want.nal_kind)
                        report("nal_kind", 32'(out_if.item.nal_kind), 32'(want.nal_kind));
                    if (out_if.item.has_byte !== want.has_byte)
                        report("has_byte", 32'(out_if.item.has_byte), 32'(want.has_byte));
                    if (out_if.item.unit_end !== want.unit_end)
                        report("unit_end", 32'(out_if.item.unit_end), 32'(want.unit_end));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                out_if.ready <= 1'b0;
            end else if (pending_bytes.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 2);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("hevc_parameter_set_extractor_unit regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        streams_built = 0;

        // junk, then a start code behind an extra zero
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_LAST, 1'b0);
        add_byte(nal_header(TYPE_VPS, 1'b0, 1'b0), 1'b0);
        // emulation prevention byte is removed
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(EP_BYTE, 1'b0);
        // four zeros in a row
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_LAST, 1'b0);
        // zero header feeds the next start code
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_LAST, 1'b0);
        add_byte(nal_header(TYPE_PPS, 1'b1, 1'b1), 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // stream that ends on a start code
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_LAST, 1'b1);
        add_byte(nal_header(TYPE_SPS, 1'b0, 1'b1), 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_LAST, 1'b1);

        total_bytes = RANDOM_BYTES;
        while (pending_bytes.size() < total_bytes)
            add_random_stream();
        total_bytes = pending_bytes.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("fed %0d bytes over %0d random streams plus directed cases", total_bytes,
                 streams_built);
        $display("checked %0d results, %0d of them unit closes, %0d errors", results_seen,
                 closes_seen, errors);
        if (errors == 0)
            $display("hevc_parameter_set_extractor_unit regression: pass");
        else
            $display("hevc_parameter_set_extractor_unit regression: fail");
        $finish;
    end

endmodule
